// ===== sv/hrpa_pkg.sv =====
// shared types, codes and the hex digit decoder for the hex record page assembler
`timescale 1ns / 1ps

package hrpa_pkg;

  // character position within a record, counted from the colon
  typedef logic [9:0] pos_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;       // a character word is accepted this cycle
    logic load_word;  // read the current page word from the store
    logic next_word;  // current page word has been taken downstream
    logic finish;     // page emission over, release the page store
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic page_ready;  // the accepted character completes a page
    logic last_word;   // the page word counter sits on the final word
  } dp_sts_t;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] KIND_DATA  = 8'h00;
  localparam logic [7:0] KIND_END   = 8'h01;
  localparam logic [7:0] BYTE_PAD   = 8'hFF;

  localparam pos_t POS_LENGTH = 10'd2;
  localparam pos_t POS_KIND   = 10'd8;
  localparam pos_t POS_DATA   = 10'd10;

  // ascii hex digit to nibble, anything else decodes as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    case (c) inside
      [8'h30:8'h39]: v = 4'(c - 8'h30);
      [8'h41:8'h46]: v = 4'(c - 8'h37);
      [8'h61:8'h66]: v = 4'(c - 8'h57);
      default:       v = 4'h0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/hex_record_page_assembler.sv =====
// Takes one hex text character per cycle; a character that completes a page
// stalls intake while the page leaves as PAGE_BYTES/2 words; each word is
// read from the page store into the output register in a read state and then
// shown, so the first word shows once the read state that follows the
// completing character is through. Synchronous active-low reset clears the decoder and
// the page address; the page store is not cleared.
`timescale 1ns / 1ps

module hex_record_page_assembler #(
  parameter int PAGE_BYTES   = 128,
  parameter int ADDRESS_STEP = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_page_word,
  output logic [5:0]  out_word_index,
  output logic [15:0] out_page_address,
  output logic        out_from_end_record,
  output logic        out_last
);

  hrpa_pkg::dp_cmd_t cmd;
  hrpa_pkg::dp_sts_t sts;

  // sequencing
  hrpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // decode and page store
  hrpa_dp #(
    .PAGE_BYTES   (PAGE_BYTES),
    .ADDRESS_STEP (ADDRESS_STEP)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_character        (in_character),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_page_word       (out_page_word),
    .out_word_index      (out_word_index),
    .out_page_address    (out_page_address),
    .out_from_end_record (out_from_end_record),
    .out_last            (out_last)
  );

endmodule

// ===== sv/hrpa_ctrl.sv =====
// controller state machine: character intake and page word emission sequencing
`timescale 1ns / 1ps

module hrpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output hrpa_pkg::dp_cmd_t cmd,
  input  hrpa_pkg::dp_sts_t sts
);

  typedef enum logic [1:0] {
    S_CHAR,
    S_READ,
    S_SHOW
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // handshake decode
  assign in_stall  = (state_r != S_CHAR);
  assign out_valid = (state_r == S_SHOW);

  // command decode and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CHAR: begin
        cmd.take = in_valid;
        if (in_valid && sts.page_ready) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.load_word = 1'b1;
        state_nxt     = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) begin
          cmd.next_word = 1'b1;
          if (sts.last_word) begin
            cmd.finish = 1'b1;
            state_nxt  = S_CHAR;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_CHAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CHAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/hrpa_dp.sv =====
// datapath: record decoding, page store banks, page address and word readout
`timescale 1ns / 1ps

module hrpa_dp #(
  parameter int PAGE_BYTES   = 128,
  parameter int ADDRESS_STEP = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_character,
  input  logic              cfg_wr_en,
  input  logic [15:0]       cfg_wr_data,
  input  hrpa_pkg::dp_cmd_t cmd,
  output hrpa_pkg::dp_sts_t sts,
  output logic [15:0]       out_page_word,
  output logic [5:0]        out_word_index,
  output logic [15:0]       out_page_address,
  output logic              out_from_end_record,
  output logic              out_last
);

  localparam int WORDS = PAGE_BYTES / 2;
  localparam int ROWS  = (PAGE_BYTES + 1) / 2;
  localparam int CW    = $clog2(PAGE_BYTES + 1);
  localparam int IW    = CW + 1;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  // record decode state
  hrpa_pkg::pos_t char_pos_r, char_pos_nxt;
  logic           in_rec_r, in_rec_nxt;
  logic [3:0]     hi_nib_r, hi_nib_nxt;
  logic [7:0]     rec_len_r, rec_len_nxt;

  // page state
  logic [CW-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic [WW-1:0]  word_cnt_r, word_cnt_nxt;
  logic [15:0]    cur_addr_r, cur_addr_nxt;
  logic           first_pend_r, first_pend_nxt;
  logic           from_end_r, from_end_nxt;
  logic [15:0]    page_word_r;

  // page store, even and odd bytes in separate banks
  logic [7:0]     even_mem [ROWS];
  logic [7:0]     odd_mem  [ROWS];

  logic [3:0]     nib;
  logic [7:0]     byte_val;
  logic           store;
  hrpa_pkg::pos_t rec_end;
  logic [RW-1:0]  wr_row;
  logic [RW-1:0]  rd_row;
  logic [IW-1:0]  lo_idx;
  logic [IW-1:0]  hi_idx;
  logic           lo_ok;
  logic           hi_ok;

  assign nib      = hrpa_pkg::hex_value(in_character);
  assign byte_val = {hi_nib_r, nib};
  assign rec_end  = hrpa_pkg::pos_t'({rec_len_r, 1'b0}) + hrpa_pkg::POS_KIND;

  // character step and page bookkeeping
  always_comb begin
    char_pos_nxt   = char_pos_r;
    in_rec_nxt     = in_rec_r;
    hi_nib_nxt     = hi_nib_r;
    rec_len_nxt    = rec_len_r;
    byte_cnt_nxt   = byte_cnt_r;
    word_cnt_nxt   = word_cnt_r;
    cur_addr_nxt   = cur_addr_r;
    first_pend_nxt = first_pend_r;
    from_end_nxt   = from_end_r;
    store          = 1'b0;
    sts.page_ready = 1'b0;
    sts.last_word  = (word_cnt_r == WW'(WORDS - 1));

    if (cmd.take) begin
      if (in_character == hrpa_pkg::CHAR_COLON) begin
        in_rec_nxt   = 1'b1;
        char_pos_nxt = 10'd1;
      end else if (in_rec_r) begin
        char_pos_nxt = char_pos_r + 10'd1;
        if (char_pos_r[0]) begin
          hi_nib_nxt = nib;
        end else if (char_pos_r == hrpa_pkg::POS_LENGTH) begin
          rec_len_nxt = byte_val;
        end else if (char_pos_r == hrpa_pkg::POS_KIND) begin
          if (byte_val == hrpa_pkg::KIND_END) begin
            // end record: pad and flush whatever the page holds
            sts.page_ready = 1'b1;
            from_end_nxt   = 1'b1;
            cur_addr_nxt   = cur_addr_r + 16'(ADDRESS_STEP);
            in_rec_nxt     = 1'b0;
          end else if (byte_val != hrpa_pkg::KIND_DATA || rec_len_r == 8'h00) begin
            in_rec_nxt = 1'b0;
          end
        end else if (char_pos_r >= hrpa_pkg::POS_DATA) begin
          // data byte into the page
          store        = 1'b1;
          byte_cnt_nxt = byte_cnt_r + CW'(1);
          if (byte_cnt_nxt == CW'(PAGE_BYTES)) begin
            sts.page_ready = 1'b1;
            from_end_nxt   = 1'b0;
            first_pend_nxt = 1'b0;
            if (!first_pend_r) begin
              cur_addr_nxt = cur_addr_r + 16'(ADDRESS_STEP);
            end
          end
          if (char_pos_r >= rec_end) begin
            in_rec_nxt = 1'b0;
          end
        end
      end
    end

    if (cmd.next_word) begin
      word_cnt_nxt = word_cnt_r + WW'(1);
    end
    if (cmd.finish) begin
      word_cnt_nxt = '0;
      byte_cnt_nxt = '0;
    end
    if (cfg_wr_en) begin
      cur_addr_nxt = cfg_wr_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r   <= '0;
      in_rec_r     <= 1'b0;
      hi_nib_r     <= '0;
      rec_len_r    <= '0;
      byte_cnt_r   <= '0;
      word_cnt_r   <= '0;
      cur_addr_r   <= '0;
      first_pend_r <= 1'b1;
      from_end_r   <= 1'b0;
    end else begin
      char_pos_r   <= char_pos_nxt;
      in_rec_r     <= in_rec_nxt;
      hi_nib_r     <= hi_nib_nxt;
      rec_len_r    <= rec_len_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      word_cnt_r   <= word_cnt_nxt;
      cur_addr_r   <= cur_addr_nxt;
      first_pend_r <= first_pend_nxt;
      from_end_r   <= from_end_nxt;
    end
  end

  // store addressing; bytes past the fill count read as padding
  assign wr_row = byte_cnt_r[RW:1];
  assign rd_row = RW'(word_cnt_r);
  assign lo_idx = IW'({word_cnt_r, 1'b0});
  assign hi_idx = lo_idx + IW'(1);
  assign lo_ok  = (lo_idx < IW'(byte_cnt_r));
  assign hi_ok  = (hi_idx < IW'(byte_cnt_r));

  // page store write and registered word read
  always_ff @(posedge clk) begin
    if (store) begin
      if (byte_cnt_r[0]) begin
        odd_mem[wr_row] <= byte_val;
      end else begin
        even_mem[wr_row] <= byte_val;
      end
    end
    if (cmd.load_word) begin
      page_word_r <= {hi_ok ? odd_mem[rd_row] : hrpa_pkg::BYTE_PAD,
                      lo_ok ? even_mem[rd_row] : hrpa_pkg::BYTE_PAD};
    end
  end

  // result word fields
  assign out_page_word         = page_word_r;
  assign out_word_index        = 6'(word_cnt_r);
  assign out_page_address      = cur_addr_r;
  assign out_from_end_record   = from_end_r;
  assign out_last              = sts.last_word;

endmodule
